@@ rtl/rfmi_pkg.sv @@
// Shared types, constants and the microcode table for the radio frame to
// MAC data indication converter. No dependencies.
`timescale 1ns / 1ps

package rfmi_pkg;

  localparam logic [7:0] MAX_FRAME_LEN = 8'd127;
  localparam int         HDR_LEN       = 48;

  // frame control decoding
  localparam logic [15:0] FC_TYPE_MASK  = 16'h0007;
  localparam logic [15:0] FC_TYPE_DATA  = 16'h0001;
  localparam logic [15:0] DST_LONG_MASK = 16'h0C00;
  localparam logic [15:0] SRC_LONG_MASK = 16'hC000;

  // fixed header bytes
  localparam logic [7:0] HDR_SYNC  = 8'hFE;
  localparam logic [7:0] HDR_CMD0  = 8'h42;
  localparam logic [7:0] HDR_CMD1  = 8'h85;
  localparam logic [7:0] HDR_BASE  = 8'd44;
  localparam logic [7:0] MODE_LONG = 8'd3;
  localparam logic [7:0] MODE_SHRT = 8'd2;

  // byte positions inside the frame (length byte excluded)
  localparam logic [7:0] POS_FC_LO   = 8'd1;
  localparam logic [7:0] POS_FC_HI   = 8'd2;
  localparam logic [7:0] POS_SEQ     = 8'd3;
  localparam logic [7:0] POS_DPAN_LO = 8'd4;
  localparam logic [7:0] POS_DPAN_HI = 8'd5;
  localparam logic [7:0] POS_DADDR   = 8'd6;
  localparam logic [7:0] POS_SPAN_LO = 8'd8;
  localparam logic [7:0] POS_SPAN_HI = 8'd9;
  localparam logic [7:0] DST_END_L   = 8'd13;
  localparam logic [7:0] DST_END_S   = 8'd7;
  localparam logic [7:0] SRC_START_L = 8'd14;
  localparam logic [7:0] SRC_START_S = 8'd10;
  localparam logic [7:0] SRC_SPAN_L  = 8'd7;
  localparam logic [7:0] SRC_SPAN_S  = 8'd1;
  localparam logic [7:0] BASE_LEN    = 8'd13;
  localparam logic [7:0] EXTRA_DST   = 8'd4;
  localparam logic [7:0] EXTRA_SRC   = 8'd6;

  // action decided for one accepted input byte
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_HDR   = 2'd1;
  localparam logic [1:0] ACT_PASS  = 2'd2;
  localparam logic [1:0] ACT_CHECK = 2'd3;

  // emit byte source select
  localparam logic [3:0] SEL_CONST    = 4'd0;
  localparam logic [3:0] SEL_LEN_ALL  = 4'd1;
  localparam logic [3:0] SEL_SRC_MODE = 4'd2;
  localparam logic [3:0] SEL_DST_MODE = 4'd3;
  localparam logic [3:0] SEL_SRC_ADDR = 4'd4;
  localparam logic [3:0] SEL_DST_ADDR = 4'd5;
  localparam logic [3:0] SEL_SRC_PAN  = 4'd6;
  localparam logic [3:0] SEL_DST_PAN  = 4'd7;
  localparam logic [3:0] SEL_SEQ      = 4'd8;
  localparam logic [3:0] SEL_PLEN     = 4'd9;
  localparam logic [3:0] SEL_RX       = 4'd10;
  localparam logic [3:0] SEL_XOR      = 4'd11;

  // jump kinds
  localparam logic [1:0] J_NEXT = 2'd0;
  localparam logic [1:0] J_HOME = 2'd1;
  localparam logic [1:0] J_WAIT = 2'd2;

  typedef logic [5:0] step_t;

  localparam step_t U_WAIT     = 6'd0;
  localparam step_t U_PASS     = 6'd1;
  localparam step_t U_CHECK    = 6'd2;
  localparam step_t U_HDR      = 6'd3;
  localparam step_t U_HDR_LAST = U_HDR + step_t'(HDR_LEN - 1);

  typedef struct packed {
    logic       emit;
    logic       xor_en;
    logic       last;
    logic [3:0] sel;
    logic [2:0] idx;
    logic [7:0] konst;
    logic [1:0] jump;
  } ucw_t;

  typedef struct packed {
    logic       fire;
    logic       xor_en;
    logic       last;
    logic [3:0] sel;
    logic [2:0] idx;
    logic [7:0] konst;
  } emit_ctl_t;

  // Microcode ROM: wait/dispatch, pass-through, check byte, 48 header steps.
  function automatic ucw_t ucode(input step_t s);
    ucw_t  w;
    step_t h;
    step_t a5;
    step_t a14;
    w   = '0;
    h   = s - U_HDR;
    a5  = h - 6'd5;
    a14 = h - 6'd14;
    w.jump = J_HOME;
    w.sel  = SEL_CONST;
    priority if (s == U_WAIT) begin
      w.jump = J_WAIT;
    end else if (s == U_PASS) begin
      w.emit   = 1'b1;
      w.xor_en = 1'b1;
      w.sel    = SEL_RX;
    end else if (s == U_CHECK) begin
      w.emit = 1'b1;
      w.last = 1'b1;
      w.sel  = SEL_XOR;
    end else if (s <= U_HDR_LAST) begin
      w.emit   = 1'b1;
      w.xor_en = (h != 6'd0);
      w.jump   = (s == U_HDR_LAST) ? J_HOME : J_NEXT;
      priority if (h == 6'd0) begin
        w.konst = HDR_SYNC;
      end else if (h == 6'd1) begin
        w.sel = SEL_LEN_ALL;
      end else if (h == 6'd2) begin
        w.konst = HDR_CMD0;
      end else if (h == 6'd3) begin
        w.konst = HDR_CMD1;
      end else if (h == 6'd4) begin
        w.sel = SEL_SRC_MODE;
      end else if (h <= 6'd12) begin
        w.sel = SEL_SRC_ADDR;
        w.idx = a5[2:0];
      end else if (h == 6'd13) begin
        w.sel = SEL_DST_MODE;
      end else if (h <= 6'd21) begin
        w.sel = SEL_DST_ADDR;
        w.idx = a14[2:0];
      end else if (h == 6'd28 || h == 6'd29) begin
        w.sel = SEL_SRC_PAN;
        w.idx = {2'b00, h[0]};
      end else if (h == 6'd30 || h == 6'd31) begin
        w.sel = SEL_DST_PAN;
        w.idx = {2'b00, h[0]};
      end else if (h == 6'd35) begin
        w.sel = SEL_SEQ;
      end else if (h == 6'd47) begin
        w.sel = SEL_PLEN;
      end else begin
        w.konst = 8'h00;
      end
    end else begin
      w.jump = J_HOME;
    end
    return w;
  endfunction

endpackage

@@ rtl/radio_frame_to_mac_indication.sv @@
// Top level of the radio frame to MAC data indication converter.
// Instantiates rfmi_seq and rfmi_frame; uses rfmi_pkg.
`timescale 1ns / 1ps
//
//  channel | dir | signals                          | contents
//  s_*     | in  | tvalid tready tdata[7:0] tuser   | frame byte, frame start flag
//  m_*     | out | tvalid tready tdata[7:0] tlast   | indication byte, check byte
//
// A byte that produces nothing is only accepted; a payload byte is accepted,
// then emitted; the last addressing byte is accepted, then followed by the 48
// header steps; the check byte is accepted, then emitted. This order is set by
// the microcode step counter, which emits at most one byte per cycle.
// Output stalls hold the sequencer on its current emit step; input is taken
// only at the wait step, also while the output register holds a byte.
// rst is synchronous, active high, and returns to the wait step with no frame.

module radio_frame_to_mac_indication (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] frame_start
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);

  rfmi_pkg::emit_ctl_t ctl;
  logic [1:0]          act;
  logic [7:0]          emit_byte;
  logic                in_fire;
  logic                out_free;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  rfmi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .act      (act),
    .out_free (out_free),
    .in_ready (s_tready),
    .ctl      (ctl)
  );

  rfmi_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .ctl         (ctl),
    .act         (act),
    .emit_byte   (emit_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      m_tdata <= emit_byte;
      m_tlast <= ctl.last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.fire |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");

endmodule

@@ rtl/rfmi_frame.sv @@
// Frame datapath: parses incoming radio bytes into frame fields, decides the
// action per byte, selects emitted bytes and keeps the running XOR. Uses rfmi_pkg.
`timescale 1ns / 1ps

module rfmi_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  input  rfmi_pkg::emit_ctl_t  ctl,
  output logic [1:0]           act,
  output logic [7:0]           emit_byte
);

  logic [7:0]  pos, pos_next;
  logic [7:0]  len, len_next;
  logic [15:0] fc, fc_next;
  logic [7:0]  seq, seq_next;
  logic [15:0] dpan, dpan_next;
  logic [63:0] daddr, daddr_next;
  logic [15:0] span, span_next;
  logic [63:0] saddr, saddr_next;
  logic [7:0]  xr, xr_next;
  logic        accepted, accepted_next;
  logic [7:0]  rx_hold;

  logic        dl, sl, dl2, sl2;
  logic [7:0]  extra, extra2, plen;
  logic [7:0]  p, dst_end, src_start, src_end;
  logic [7:0]  dlane, slane;
  logic [15:0] fc_hi;

  assign dl = (fc & rfmi_pkg::DST_LONG_MASK) == rfmi_pkg::DST_LONG_MASK;
  assign sl = (fc & rfmi_pkg::SRC_LONG_MASK) == rfmi_pkg::SRC_LONG_MASK;
  assign extra = (dl ? rfmi_pkg::EXTRA_DST : 8'd0) + (sl ? rfmi_pkg::EXTRA_SRC : 8'd0);
  assign plen  = len - rfmi_pkg::BASE_LEN - extra;

  assign fc_hi  = {rx_byte, fc[7:0]};
  assign dl2    = (fc_hi & rfmi_pkg::DST_LONG_MASK) == rfmi_pkg::DST_LONG_MASK;
  assign sl2    = (fc_hi & rfmi_pkg::SRC_LONG_MASK) == rfmi_pkg::SRC_LONG_MASK;
  assign extra2 = (dl2 ? rfmi_pkg::EXTRA_DST : 8'd0) + (sl2 ? rfmi_pkg::EXTRA_SRC : 8'd0);

  assign p         = (pos != 8'hFF) ? pos + 8'd1 : pos;
  assign dst_end   = dl ? rfmi_pkg::DST_END_L : rfmi_pkg::DST_END_S;
  assign src_start = dl ? rfmi_pkg::SRC_START_L : rfmi_pkg::SRC_START_S;
  assign src_end   = src_start + (sl ? rfmi_pkg::SRC_SPAN_L : rfmi_pkg::SRC_SPAN_S);
  assign dlane     = p - rfmi_pkg::POS_DADDR;
  assign slane     = p - src_start;

  // parse one accepted byte
  always_comb begin
    pos_next      = pos;
    len_next      = len;
    fc_next       = fc;
    seq_next      = seq;
    dpan_next     = dpan;
    daddr_next    = daddr;
    span_next     = span;
    saddr_next    = saddr;
    accepted_next = accepted;
    act           = rfmi_pkg::ACT_NONE;
    if (in_fire) begin
      if (frame_start) begin
        pos_next      = 8'd0;
        len_next      = rx_byte;
        fc_next       = 16'd0;
        seq_next      = 8'd0;
        dpan_next     = 16'd0;
        daddr_next    = 64'd0;
        span_next     = 16'd0;
        saddr_next    = 64'd0;
        accepted_next = (rx_byte <= rfmi_pkg::MAX_FRAME_LEN);
      end else if (accepted) begin
        pos_next = p;
        priority if (p > len) begin
          accepted_next = 1'b0;
        end else if (p == rfmi_pkg::POS_FC_LO) begin
          fc_next = {8'd0, rx_byte};
          if (({8'd0, rx_byte} & rfmi_pkg::FC_TYPE_MASK) != rfmi_pkg::FC_TYPE_DATA) begin
            accepted_next = 1'b0;
          end
        end else if (p == rfmi_pkg::POS_FC_HI) begin
          fc_next = fc_hi;
          if (len < rfmi_pkg::BASE_LEN + extra2) begin
            accepted_next = 1'b0;
          end
        end else begin
          priority if (p == rfmi_pkg::POS_SEQ) begin
            seq_next = rx_byte;
          end else if (p <= rfmi_pkg::POS_DPAN_HI) begin
            if (p == rfmi_pkg::POS_DPAN_LO) dpan_next[7:0] = rx_byte;
            else dpan_next[15:8] = rx_byte;
          end else if (p <= dst_end) begin
            daddr_next[dlane[2:0]*8 +: 8] = rx_byte;
          end else if (!dl && p <= rfmi_pkg::POS_SPAN_HI) begin
            if (p == rfmi_pkg::POS_SPAN_LO) span_next[7:0] = rx_byte;
            else span_next[15:8] = rx_byte;
          end else if (p >= src_start && p <= src_end) begin
            saddr_next[slane[2:0]*8 +: 8] = rx_byte;
          end else begin
            seq_next = seq;
          end
          priority if (p == src_end) begin
            act = rfmi_pkg::ACT_HDR;
          end else if (p > src_end && ({1'b0, p} + 9'd2) <= {1'b0, len}) begin
            act = rfmi_pkg::ACT_PASS;
          end else if (({1'b0, p} + 9'd1) == {1'b0, len}) begin
            act           = rfmi_pkg::ACT_CHECK;
            accepted_next = 1'b0;
          end else begin
            act = rfmi_pkg::ACT_NONE;
          end
        end
      end
    end
  end

  // emitted byte source
  always_comb begin
    unique case (ctl.sel)
      rfmi_pkg::SEL_CONST:    emit_byte = ctl.konst;
      rfmi_pkg::SEL_LEN_ALL:  emit_byte = rfmi_pkg::HDR_BASE + plen;
      rfmi_pkg::SEL_SRC_MODE: emit_byte = sl ? rfmi_pkg::MODE_LONG : rfmi_pkg::MODE_SHRT;
      rfmi_pkg::SEL_DST_MODE: emit_byte = dl ? rfmi_pkg::MODE_LONG : rfmi_pkg::MODE_SHRT;
      rfmi_pkg::SEL_SRC_ADDR: emit_byte = saddr[ctl.idx*8 +: 8];
      rfmi_pkg::SEL_DST_ADDR: emit_byte = daddr[ctl.idx*8 +: 8];
      rfmi_pkg::SEL_SRC_PAN:  emit_byte = ctl.idx[0] ? span[15:8] : span[7:0];
      rfmi_pkg::SEL_DST_PAN:  emit_byte = ctl.idx[0] ? dpan[15:8] : dpan[7:0];
      rfmi_pkg::SEL_SEQ:      emit_byte = seq;
      rfmi_pkg::SEL_PLEN:     emit_byte = plen;
      rfmi_pkg::SEL_RX:       emit_byte = rx_hold;
      rfmi_pkg::SEL_XOR:      emit_byte = xr;
      default:                emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    xr_next = xr;
    if (in_fire && frame_start) begin
      xr_next = 8'd0;
    end else if (ctl.fire && ctl.xor_en) begin
      xr_next = xr ^ emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted <= 1'b0;
      pos      <= 8'd0;
    end else begin
      accepted <= accepted_next;
      pos      <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    len   <= len_next;
    fc    <= fc_next;
    seq   <= seq_next;
    dpan  <= dpan_next;
    daddr <= daddr_next;
    span  <= span_next;
    saddr <= saddr_next;
    xr    <= xr_next;
    if (in_fire) begin
      rx_hold <= rx_byte;
    end
  end

  a_check_closes: assert property (@(posedge clk) disable iff (rst)
    in_fire && !frame_start && act == rfmi_pkg::ACT_CHECK |=> !accepted)
    else $error("frame still open after check byte");

  a_hdr_data_only: assert property (@(posedge clk) disable iff (rst)
    ctl.fire && ctl.sel == rfmi_pkg::SEL_SRC_MODE |->
      (fc & rfmi_pkg::FC_TYPE_MASK) == rfmi_pkg::FC_TYPE_DATA)
    else $error("header emitted for non-data frame");

endmodule

@@ rtl/rfmi_seq.sv @@
// Microcoded sequencer: step counter, control word from the ROM in rfmi_pkg,
// dispatch on the byte action and stall on a full output. Uses rfmi_pkg.
`timescale 1ns / 1ps

module rfmi_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [1:0]           act,
  input  logic                 out_free,
  output logic                 in_ready,
  output rfmi_pkg::emit_ctl_t  ctl
);

  rfmi_pkg::step_t step, step_next;
  rfmi_pkg::ucw_t  uw;
  logic            adv;

  assign uw       = rfmi_pkg::ucode(step);
  assign in_ready = (uw.jump == rfmi_pkg::J_WAIT);
  assign adv      = !uw.emit || out_free;

  assign ctl.fire   = uw.emit && out_free;
  assign ctl.xor_en = uw.xor_en;
  assign ctl.last   = uw.last;
  assign ctl.sel    = uw.sel;
  assign ctl.idx    = uw.idx;
  assign ctl.konst  = uw.konst;

  always_comb begin
    step_next = step;
    unique case (uw.jump)
      rfmi_pkg::J_WAIT: begin
        if (in_fire) begin
          unique case (act)
            rfmi_pkg::ACT_NONE:  step_next = step;
            rfmi_pkg::ACT_HDR:   step_next = rfmi_pkg::U_HDR;
            rfmi_pkg::ACT_PASS:  step_next = rfmi_pkg::U_PASS;
            rfmi_pkg::ACT_CHECK: step_next = rfmi_pkg::U_CHECK;
            default:             step_next = step;
          endcase
        end
      end
      rfmi_pkg::J_NEXT: begin
        if (adv) step_next = step + 6'd1;
      end
      rfmi_pkg::J_HOME: begin
        if (adv) step_next = rfmi_pkg::U_WAIT;
      end
      default: step_next = rfmi_pkg::U_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rfmi_pkg::U_WAIT;
    end else begin
      step <= step_next;
    end
  end

  a_last_home: assert property (@(posedge clk) disable iff (rst)
    ctl.fire && ctl.last |=> step == rfmi_pkg::U_WAIT)
    else $error("sequencer did not return after check byte");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= rfmi_pkg::U_HDR_LAST)
    else $error("step counter outside program");

endmodule
